/* rtl/core/cse_pkg.sv */
`default_nettype none

package cse_pkg;

    localparam int PAYLOAD_BYTES_DEF = 8;
    localparam int PAYLOAD_W = 64;
    localparam int START_W = 6;
    localparam int LEN_W = 7;
    localparam int BYTE_W = 4;
    localparam int BIT_W = 3;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_EXTRACT = 2'd1;
    localparam logic [1:0] MODE_INSERT = 2'd2;

    typedef struct packed {
        logic [1:0]           mode;
        logic [PAYLOAD_W-1:0] payload_in;
        logic [START_W-1:0]   start_bit;
        logic [LEN_W-1:0]     bit_length;
        logic                 big_endian_order;
        logic [PAYLOAD_W-1:0] raw_in;
    } item_t;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] raw_out;
        logic [PAYLOAD_W-1:0] payload_out;
        logic                 range_error;
    } result_t;

    typedef struct packed {
        logic load;
        logic step;
    } walk_ctl_t;

    typedef struct packed {
        logic over;
        logic last;
    } walk_sts_t;

endpackage

`default_nettype wire

/* rtl/core/can_signal_extract_insert.sv */
// Holds one CAN frame payload and serves load, extract and insert items, one at a
// time: an item is taken when start is high and busy is low, and its single result
// is shown on result for exactly one cycle, marked by done, which the receiver must
// take then. A load or an unused mode gives its result in the cycle after it is
// taken, as do an extract or insert of zero length or of a length beyond the payload.
// Otherwise the field is walked one bit per cycle through a shared bit-position
// stepper until bit_length bits are done, or until the walk leaves the payload early
// and flags range_error. busy stays high during the walk.
`default_nettype none

module can_signal_extract_insert
    import cse_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire item_t item,
    output logic       done,
    output result_t    result
);

    localparam logic [PAYLOAD_W-1:0] PayloadMask =
        {PAYLOAD_W{1'b1}} >> (PAYLOAD_W - 8 * PAYLOAD_BYTES);
    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(8 * PAYLOAD_BYTES);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [PAYLOAD_W-1:0] frame_payload_reg, frame_payload_next;
    logic [1:0]           mode_reg, mode_next;
    result_t              result_reg, result_next;
    logic                 done_reg, done_next;

    walk_ctl_t            ctl;
    walk_sts_t            sts;
    logic [PAYLOAD_W-1:0] value_next;
    logic [PAYLOAD_W-1:0] merged_next;

    cse_walk_unit #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_walk (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .start_bit        (item.start_bit),
        .bit_length       (item.bit_length),
        .big_endian_order (item.big_endian_order),
        .raw_in           (item.raw_in),
        .payload          (frame_payload_reg),
        .sts              (sts),
        .value_next       (value_next),
        .merged_next      (merged_next)
    );

    always_comb
    begin
        state_next = state_reg;
        frame_payload_next = frame_payload_reg;
        mode_next = mode_reg;
        result_next = result_reg;
        done_next = 1'b0;
        ctl = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    result_next.raw_out = '0;
                    result_next.payload_out = frame_payload_reg;
                    result_next.range_error = 1'b0;
                    case (item.mode)
                        MODE_LOAD:
                        begin
                            frame_payload_next = item.payload_in & PayloadMask;
                            result_next.payload_out = item.payload_in & PayloadMask;
                            done_next = 1'b1;
                        end
                        MODE_EXTRACT, MODE_INSERT:
                        begin
                            if (item.bit_length == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else if (item.bit_length > MaxLen)
                            begin
                                result_next.range_error = 1'b1;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                ctl.load = 1'b1;
                                mode_next = item.mode;
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                result_next.raw_out = '0;
                result_next.payload_out = frame_payload_reg;
                result_next.range_error = 1'b0;
                if (sts.over)
                begin
                    result_next.range_error = 1'b1;
                    done_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctl.step = 1'b1;
                    if (sts.last)
                    begin
                        if (mode_reg == MODE_INSERT)
                        begin
                            frame_payload_next = merged_next;
                            result_next.payload_out = merged_next;
                        end
                        else
                        begin
                            result_next.raw_out = value_next;
                        end
                        done_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            frame_payload_reg <= '0;
            mode_reg <= MODE_LOAD;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            frame_payload_reg <= frame_payload_next;
            mode_reg <= mode_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign result = result_reg;

    a_err_zero_raw: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.range_error |-> result.raw_out == '0)
        else $error("range error with nonzero raw value");

    a_walk_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && $past(busy) |-> done)
        else $error("walk ended without a result");

    a_payload_masked: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.payload_out & ~PayloadMask) == '0)
        else $error("payload bits beyond frame length");

    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.mode == MODE_LOAD |=> done && !busy)
        else $error("load item did not finish in one cycle");

endmodule

`default_nettype wire

/* rtl/core/cse_walk_unit.sv */
`default_nettype none

module cse_walk_unit
    import cse_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire walk_ctl_t            ctl,
    input  wire logic [START_W-1:0]   start_bit,
    input  wire logic [LEN_W-1:0]     bit_length,
    input  wire logic                 big_endian_order,
    input  wire logic [PAYLOAD_W-1:0] raw_in,
    input  wire logic [PAYLOAD_W-1:0] payload,
    output walk_sts_t                 sts,
    output logic [PAYLOAD_W-1:0]      value_next,
    output logic [PAYLOAD_W-1:0]      merged_next
);

    localparam logic [BYTE_W-1:0] ByteLimit = BYTE_W'(PAYLOAD_BYTES);

    logic [BYTE_W-1:0]    byte_reg, byte_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic [LEN_W-1:0]     cnt_reg, cnt_next;
    logic [LEN_W-1:0]     len_reg;
    logic                 moto_reg;
    logic [PAYLOAD_W-1:0] ins_reg;
    logic [PAYLOAD_W-1:0] value_reg;
    logic [PAYLOAD_W-1:0] merged_reg;

    logic [5:0]       pos;
    logic [5:0]       sig;
    logic [LEN_W-1:0] sig_full;

    always_comb
    begin
        pos = {byte_reg[BIT_W-1:0], bit_reg};
        sig_full = moto_reg ? (len_reg - LEN_W'(1) - cnt_reg) : cnt_reg;
        sig = sig_full[5:0];
        value_next = value_reg | (PAYLOAD_W'(merged_reg[pos]) << sig);
        merged_next = merged_reg;
        merged_next[pos] = ins_reg[sig];
        cnt_next = cnt_reg + LEN_W'(1);
        byte_next = byte_reg;
        bit_next = bit_reg;
        if (moto_reg)
        begin
            if (bit_reg != BIT_W'(0))
            begin
                bit_next = bit_reg - BIT_W'(1);
            end
            else
            begin
                byte_next = byte_reg + BYTE_W'(1);
                bit_next = BIT_W'(7);
            end
        end
        else
        begin
            if (bit_reg != BIT_W'(7))
            begin
                bit_next = bit_reg + BIT_W'(1);
            end
            else
            begin
                byte_next = byte_reg + BYTE_W'(1);
                bit_next = BIT_W'(0);
            end
        end
        sts.over = (byte_reg >= ByteLimit);
        sts.last = (cnt_next == len_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
            bit_reg  <= '0;
            cnt_reg  <= '0;
            len_reg  <= '0;
            moto_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            byte_reg <= BYTE_W'(start_bit[START_W-1:BIT_W]);
            bit_reg  <= start_bit[BIT_W-1:0];
            cnt_reg  <= '0;
            len_reg  <= bit_length;
            moto_reg <= big_endian_order;
        end
        else if (ctl.step)
        begin
            byte_reg <= byte_next;
            bit_reg  <= bit_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            ins_reg    <= raw_in;
            value_reg  <= '0;
            merged_reg <= payload;
        end
        else if (ctl.step)
        begin
            value_reg  <= value_next;
            merged_reg <= merged_next;
        end
    end

endmodule

`default_nettype wire
